/* rtl/ppss_pkg.sv */
`default_nettype none

package ppss_pkg;

    localparam int KIND_W    = 2;
    localparam int TICK_W    = 16;
    localparam int WCNT_W    = 16;
    localparam int BAR_W     = 8;
    localparam int REG_IDX_W = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

    localparam logic RPT_PERIOD = 1'b0;
    localparam logic RPT_DC     = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_AC_TIMEOUT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BAR_LENGTH = 2'd2;

    localparam int AC_TIMEOUT_RST = 200000;
    localparam int FULL_SCALE_RST = 4094;
    localparam int BAR_LENGTH_RST = 50;
    localparam int PERIOD_RST     = 95;

    // width of one queued report job
    function automatic int job_bits(input int s, input int c);
        return 2 + TICK_W + 2 * WCNT_W + 3 * c + 7 * s;
    endfunction

endpackage

`default_nettype wire

/* rtl/ppss_in_if.sv */
`default_nettype none

interface ppss_in_if #(
    parameter int SAMPLE_BITS = 12
) ();
    import ppss_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TICK_W-1:0]      capture_time;

    modport source (output valid, kind, sample, capture_time, input ready);
    modport sink (input valid, kind, sample, capture_time, output ready);
endinterface

`default_nettype wire

/* rtl/ppss_out_if.sv */
`default_nettype none

interface ppss_out_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 24
) ();
    import ppss_pkg::*;

    logic                                valid;
    logic                                ready;
    logic                                report_kind;
    logic [TICK_W-1:0]                   period_ticks;
    logic [COUNT_BITS-1:0]               sample_count;
    logic [COUNT_BITS+SAMPLE_BITS-1:0]   sample_sum;
    logic [COUNT_BITS+2*SAMPLE_BITS-1:0] square_sum;
    logic [SAMPLE_BITS-1:0]              min_sample;
    logic [SAMPLE_BITS-1:0]              max_sample;
    logic [SAMPLE_BITS-1:0]              peak_to_peak;
    logic [SAMPLE_BITS-1:0]              dc_mean;
    logic [BAR_W-1:0]                    dc_bar;
    logic                                ac_absent;

    modport source (
        output valid, report_kind, period_ticks, sample_count, sample_sum, square_sum,
               min_sample, max_sample, peak_to_peak, dc_mean, dc_bar, ac_absent,
        input  ready
    );
    modport sink (
        input  valid, report_kind, period_ticks, sample_count, sample_sum, square_sum,
               min_sample, max_sample, peak_to_peak, dc_mean, dc_bar, ac_absent,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/ppss_fifo.sv */
`default_nettype none

module ppss_fifo #(
    parameter int W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [W-1:0]              i_data,
    input  logic                      i_pop,
    output logic [W-1:0]              o_data,
    output logic                      o_empty,
    output logic [ppss_pkg::Q_LVL_W-1:0] o_level
);
    import ppss_pkg::*;

    logic [W-1:0]       r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_LVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level != Q_LVL_W'(Q_DEPTH)))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_level != '0))
        else $error("job popped from an empty queue");

    a_level_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_level == Q_LVL_W'($past(r_level) + 1'b1)))
        else $error("queue level lost a push");
`endif

endmodule

`default_nettype wire

/* rtl/ppss_div.sv */
`default_nettype none

module ppss_div #(
    parameter int N = 28,
    parameter int D = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quo
);
    localparam int CNT_W = $clog2(N + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N-1:0]     r_quo;
    logic [D-1:0]     r_rem;
    logic [D-1:0]     r_dvs;

    logic [D:0]   w_shift;
    logic [D:0]   w_diff;
    logic         w_ge;
    logic [D-1:0] w_rem_n;

    // restoring division, one quotient bit a cycle
    assign w_shift = {r_rem, r_quo[N-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_rem_n = w_ge ? w_diff[D-1:0] : w_shift[D-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[N-2:0], w_ge};
            r_rem <= w_rem_n;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* rtl/ppss_front.sv */
`default_nettype none

module ppss_front #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ppss_in_if.sink                       i_in,
    input  logic [COUNT_BITS-1:0]         i_ac_timeout,
    input  logic [ppss_pkg::Q_LVL_W-1:0]  i_q_level,
    output logic                          o_push,
    output logic [ppss_pkg::job_bits(SAMPLE_BITS, COUNT_BITS)-1:0] o_job
);
    import ppss_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int C      = COUNT_BITS;
    localparam int PSUM_W = C + S;
    localparam int PSQ_W  = C + 2 * S;
    localparam int WSUM_W = WCNT_W + S;

    typedef struct packed {
        logic              is_dc;
        logic [TICK_W-1:0] period_ticks;
        logic [C-1:0]      count;
        logic [PSUM_W-1:0] sum;
        logic [PSQ_W-1:0]  sq;
        logic [S-1:0]      min_s;
        logic [S-1:0]      max_s;
        logic [S-1:0]      p2p;
        logic [WSUM_W-1:0] wsum;
        logic [WCNT_W-1:0] wcount;
        logic              ac_absent;
    } t_job;

    logic              w_accept;
    logic [2*S-1:0]    w_sq;

    logic              r_s1_valid;
    logic [KIND_W-1:0] r_s1_kind;
    logic [S-1:0]      r_s1_sample;
    logic [2*S-1:0]    r_s1_sq;
    logic [TICK_W-1:0] r_s1_cap;

    logic [TICK_W-1:0] r_last_cap;
    logic [TICK_W-1:0] r_period;
    logic [C-1:0]      r_pcount;
    logic [PSUM_W-1:0] r_psum;
    logic [PSQ_W-1:0]  r_psq;
    logic [S-1:0]      r_min;
    logic [S-1:0]      r_max;
    logic [WCNT_W-1:0] r_wcount;
    logic [WSUM_W-1:0] r_wsum;

    logic              w_is_smp;
    logic              w_is_cap;
    logic              w_is_tick;
    logic [C:0]        w_cnt_add;
    logic [PSUM_W:0]   w_psum_add;
    logic [PSQ_W:0]    w_psq_add;
    logic [WSUM_W:0]   w_wsum_add;
    logic [TICK_W-1:0] n_period;
    t_job              w_job;

    // two slots kept free: one for the item in the square stage
    assign i_in.ready = (i_q_level <= Q_LVL_W'(Q_DEPTH - 2));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_sq       = i_in.sample * i_in.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind   <= i_in.kind;
            r_s1_sample <= i_in.sample;
            r_s1_sq     <= w_sq;
            r_s1_cap    <= i_in.capture_time;
        end
    end

    assign w_is_smp  = r_s1_valid && (r_s1_kind == KIND_SAMPLE);
    assign w_is_cap  = r_s1_valid && (r_s1_kind == KIND_CAPTURE);
    assign w_is_tick = r_s1_valid && (r_s1_kind == KIND_TICK);

    // saturating adds: a carry out pins the sum at all ones
    assign w_cnt_add  = {1'b0, r_pcount} + (C + 1)'(1);
    assign w_psum_add = {1'b0, r_psum} + (PSUM_W + 1)'(r_s1_sample);
    assign w_psq_add  = {1'b0, r_psq} + (PSQ_W + 1)'(r_s1_sq);
    assign w_wsum_add = {1'b0, r_wsum} + (WSUM_W + 1)'(r_s1_sample);

    // a capture that did not rise keeps the old period
    assign n_period = (r_s1_cap > r_last_cap) ? (r_s1_cap - r_last_cap) : r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cap <= '0;
            r_period   <= TICK_W'(PERIOD_RST);
            r_pcount   <= '0;
            r_psum     <= '0;
            r_psq      <= '0;
            r_min      <= '1;
            r_max      <= '0;
            r_wcount   <= '0;
            r_wsum     <= '0;
        end else if (w_is_smp) begin
            r_pcount <= w_cnt_add[C] ? r_pcount : w_cnt_add[C-1:0];
            r_psum   <= w_psum_add[PSUM_W] ? '1 : w_psum_add[PSUM_W-1:0];
            r_psq    <= w_psq_add[PSQ_W] ? '1 : w_psq_add[PSQ_W-1:0];
            if (r_s1_sample < r_min) begin
                r_min <= r_s1_sample;
            end
            if (r_s1_sample > r_max) begin
                r_max <= r_s1_sample;
            end
            // a full window count drops the sample so the mean stays true
            if (r_wcount != '1) begin
                r_wcount <= r_wcount + 1'b1;
                r_wsum   <= w_wsum_add[WSUM_W] ? '1 : w_wsum_add[WSUM_W-1:0];
            end
        end else if (w_is_cap) begin
            r_last_cap <= r_s1_cap;
            r_period   <= n_period;
            r_pcount   <= '0;
            r_psum     <= '0;
            r_psq      <= '0;
            r_min      <= '1;
            r_max      <= '0;
        end else if (w_is_tick) begin
            r_wcount <= '0;
            r_wsum   <= '0;
        end
    end

    always_comb begin
        w_job = '0;
        if (w_is_tick) begin
            w_job.is_dc     = 1'b1;
            w_job.wsum      = r_wsum;
            w_job.wcount    = r_wcount;
            w_job.ac_absent = (r_pcount > i_ac_timeout);
        end else begin
            w_job.period_ticks = n_period;
            w_job.count        = r_pcount;
            w_job.sum          = r_psum;
            w_job.sq           = r_psq;
            if (r_pcount != '0) begin
                w_job.min_s = r_min;
                w_job.max_s = r_max;
                w_job.p2p   = (r_max >= r_min) ? (r_max - r_min) : '0;
            end
        end
    end

    assign o_push = w_is_cap || w_is_tick;
    assign o_job  = w_job;

endmodule

`default_nettype wire

/* rtl/ppss_back.sv */
`default_nettype none

module ppss_back #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ppss_pkg::job_bits(SAMPLE_BITS, COUNT_BITS)-1:0] i_job,
    input  logic                       i_q_empty,
    output logic                       o_pop,
    input  logic [SAMPLE_BITS-1:0]     i_full_scale,
    input  logic [ppss_pkg::BAR_W-1:0] i_bar_length,
    ppss_out_if.source                 o_out
);
    import ppss_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int C      = COUNT_BITS;
    localparam int PSUM_W = C + S;
    localparam int PSQ_W  = C + 2 * S;
    localparam int WSUM_W = WCNT_W + S;
    localparam int DIV_W  = WSUM_W;

    typedef struct packed {
        logic              is_dc;
        logic [TICK_W-1:0] period_ticks;
        logic [C-1:0]      count;
        logic [PSUM_W-1:0] sum;
        logic [PSQ_W-1:0]  sq;
        logic [S-1:0]      min_s;
        logic [S-1:0]      max_s;
        logic [S-1:0]      p2p;
        logic [WSUM_W-1:0] wsum;
        logic [WCNT_W-1:0] wcount;
        logic              ac_absent;
    } t_job;

    typedef struct packed {
        logic              report_kind;
        logic [TICK_W-1:0] period_ticks;
        logic [C-1:0]      sample_count;
        logic [PSUM_W-1:0] sample_sum;
        logic [PSQ_W-1:0]  square_sum;
        logic [S-1:0]      min_sample;
        logic [S-1:0]      max_sample;
        logic [S-1:0]      peak_to_peak;
        logic [S-1:0]      dc_mean;
        logic [BAR_W-1:0]  dc_bar;
        logic              ac_absent;
    } t_res;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MEAN = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_BAR  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_job               w_job;
    logic               w_out_free;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_dividend;
    logic [WCNT_W-1:0]  w_divisor;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_quo;
    logic               w_load_period;
    logic               w_load_dc;
    logic [S-1:0]       w_fs;
    logic [S+BAR_W-1:0] w_prod;
    logic [S-1:0]       w_mean;
    logic [BAR_W-1:0]   w_bar;
    t_res               w_res;

    logic               r_wcnt_zero;
    logic               r_ac;
    logic [S-1:0]       r_mean;
    logic [BAR_W-1:0]   r_bar;
    logic               r_out_valid;
    t_res               r_res;

    assign w_job      = t_job'(i_job);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_fs       = (i_full_scale == '0) ? S'(1) : i_full_scale;
    assign w_prod     = r_mean * i_bar_length;

    always_comb begin
        n_state       = r_state;
        o_pop         = 1'b0;
        w_div_start   = 1'b0;
        w_dividend    = '0;
        w_divisor     = '0;
        w_load_period = 1'b0;
        w_load_dc     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (w_job.is_dc) begin
                        o_pop       = 1'b1;
                        w_div_start = 1'b1;
                        w_dividend  = w_job.wsum;
                        w_divisor   = w_job.wcount;
                        n_state     = ST_MEAN;
                    end else if (w_out_free) begin
                        o_pop         = 1'b1;
                        w_load_period = 1'b1;
                    end
                end
            end
            ST_MEAN: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                w_div_start = 1'b1;
                w_dividend  = DIV_W'(w_prod);
                w_divisor   = WCNT_W'(w_fs);
                n_state     = ST_BAR;
            end
            ST_BAR: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load_dc = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    ppss_div #(
        .N (DIV_W),
        .D (WCNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo)
    );

    // empty window gives zero, not the all-ones of a divide by zero
    assign w_mean = r_wcnt_zero ? '0 :
                    (|w_div_quo[DIV_W-1:S]) ? '1 : w_div_quo[S-1:0];
    assign w_bar  = ((|w_div_quo[DIV_W-1:BAR_W]) || (w_div_quo[BAR_W-1:0] > i_bar_length))
                    ? i_bar_length : w_div_quo[BAR_W-1:0];

    always_comb begin
        w_res = '0;
        if (w_load_dc) begin
            w_res.report_kind = RPT_DC;
            w_res.dc_mean     = r_mean;
            w_res.dc_bar      = r_bar;
            w_res.ac_absent   = r_ac;
        end else begin
            w_res.report_kind  = RPT_PERIOD;
            w_res.period_ticks = w_job.period_ticks;
            w_res.sample_count = w_job.count;
            w_res.sample_sum   = w_job.sum;
            w_res.square_sum   = w_job.sq;
            w_res.min_sample   = w_job.min_s;
            w_res.max_sample   = w_job.max_s;
            w_res.peak_to_peak = w_job.p2p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_period || w_load_dc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_div_start) begin
            r_wcnt_zero <= (w_job.wcount == '0);
            r_ac        <= w_job.ac_absent;
        end
        if (r_state == ST_MEAN && w_div_done) begin
            r_mean <= w_mean;
        end
        if (r_state == ST_BAR && w_div_done) begin
            r_bar <= w_bar;
        end
        if (w_load_period || w_load_dc) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.report_kind  = r_res.report_kind;
    assign o_out.period_ticks = r_res.period_ticks;
    assign o_out.sample_count = r_res.sample_count;
    assign o_out.sample_sum   = r_res.sample_sum;
    assign o_out.square_sum   = r_res.square_sum;
    assign o_out.min_sample   = r_res.min_sample;
    assign o_out.max_sample   = r_res.max_sample;
    assign o_out.peak_to_peak = r_res.peak_to_peak;
    assign o_out.dc_mean      = r_res.dc_mean;
    assign o_out.dc_bar       = r_res.dc_bar;
    assign o_out.ac_absent    = r_res.ac_absent;

endmodule

`default_nettype wire

/* rtl/per_period_signal_statistics.sv */
// Per-period signal statistics for a true-RMS meter front end.
// i_in carries items: ADC samples, rising-edge timer captures and millisecond
// ticks. o_out carries reports: a period report for each capture and a DC
// report (mean, bar, AC-absent flag) for each tick. Samples give no report.
// i_cfg_we/i_cfg_idx/i_cfg_data write AC timeout (0), full scale (1) and bar
// length (2); write them only while no report is outstanding.
// Throughput: one item a cycle while two of the four queue slots are free;
// samples are accumulated at that rate behind a registered squaring stage.
// A period report passes the squaring stage and the job queue into the
// output register. A DC report needs two 28-step restoring divisions
// (SAMPLE_BITS + 16 steps each) in the report unit, which takes no other
// job until that report is loaded into the output register.
// When o_out is stalled the output register holds, jobs pile up in the queue
// and i_in.ready drops once fewer than two queue slots are free.
// Reset (synchronous, active low) clears all accumulators, the period to 95
// ticks, and restores the register defaults; no clearing pass is needed.
`default_nettype none

module per_period_signal_statistics #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ppss_in_if.sink                        i_in,
    ppss_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [ppss_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [COUNT_BITS-1:0]          i_cfg_data
);
    import ppss_pkg::*;

    localparam int JOB_W = job_bits(SAMPLE_BITS, COUNT_BITS);

    logic [COUNT_BITS-1:0]  r_ac_timeout;
    logic [SAMPLE_BITS-1:0] r_full_scale;
    logic [BAR_W-1:0]       r_bar_length;

    logic               w_push;
    logic [JOB_W-1:0]   w_push_job;
    logic               w_pop;
    logic [JOB_W-1:0]   w_head_job;
    logic               w_q_empty;
    logic [Q_LVL_W-1:0] w_q_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac_timeout <= COUNT_BITS'(AC_TIMEOUT_RST);
            r_full_scale <= SAMPLE_BITS'(FULL_SCALE_RST);
            r_bar_length <= BAR_W'(BAR_LENGTH_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AC_TIMEOUT: r_ac_timeout <= i_cfg_data;
                REG_FULL_SCALE: r_full_scale <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_BAR_LENGTH: r_bar_length <= i_cfg_data[BAR_W-1:0];
                default: ;
            endcase
        end
    end

    ppss_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_ac_timeout (r_ac_timeout),
        .i_q_level    (w_q_level),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    ppss_fifo #(
        .W (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_empty (w_q_empty),
        .o_level (w_q_level)
    );

    ppss_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_head_job),
        .i_q_empty    (w_q_empty),
        .o_pop        (w_pop),
        .i_full_scale (r_full_scale),
        .i_bar_length (r_bar_length),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire
